### hdl/mafe_pkg.sv
// ----------------------------------------------------------------------------
// mafe_pkg
// Widths, register indexes and the control/status types shared by the
// moving-average forecast error block.
// ----------------------------------------------------------------------------
package mafe_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int WLEN_W     = 9;
    localparam int SLEN_W     = 11;
    localparam int TOTAL_W    = 25;
    localparam int PROD_W     = 26;
    localparam int DIFF_W     = 27;
    localparam int ABS_W      = 26;
    localparam int SQ_W       = 52;
    localparam int ERR_W      = 58;
    localparam int ROOT_W     = 45;
    localparam int REM_W      = 46;
    localparam int DEN_W      = 20;
    localparam int RMS_W      = 32;
    localparam int ITER_W     = 6;
    localparam int ROOT_STEPS = 45;
    localparam int DIV_STEPS  = 45;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 11;

    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LEN = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERIES_LEN = 1'b1;

    localparam logic [WLEN_W-1:0] WLEN_RESET = 9'd4;
    localparam logic [SLEN_W-1:0] SLEN_RESET = 11'd16;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic upd;
        logic sq;
        logic acc;
        logic root_init;
        logic root_step;
        logic div_init;
        logic div_step;
        logic load_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic last;
        logic bad;
    } t_stat;

endpackage

### hdl/mafe_if.sv
// ----------------------------------------------------------------------------
// mafe_if
// Valid/ready channels of the block: sample input, result output and
// configuration writes.
// ----------------------------------------------------------------------------
interface mafe_sample_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [mafe_pkg::SAMPLE_W-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink (input valid, input sample, output ready);
endinterface

interface mafe_result_if;
    logic                              valid;
    logic                              ready;
    logic [mafe_pkg::RMS_W-1:0]        rms_result;
    logic                              bad_config;

    modport source (output valid, output rms_result, output bad_config, input ready);
    modport sink (input valid, input rms_result, input bad_config, output ready);
endinterface

interface mafe_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [mafe_pkg::CFG_IDX_W-1:0]     index;
    logic [mafe_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

### hdl/mafe_ram.sv
// ----------------------------------------------------------------------------
// mafe_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module mafe_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### hdl/mafe_ctrl.sv
// ----------------------------------------------------------------------------
// mafe_ctrl
// Sequencer of the block: steps each sample through the datapath and runs
// the square root and the division at the end of a well-configured series.
// ----------------------------------------------------------------------------
module mafe_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  mafe_pkg::t_stat i_stat,
    output mafe_pkg::t_cmd  o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_UPD,
        ST_SQ,
        ST_ACC,
        ST_RINIT,
        ST_ROOT,
        ST_DINIT,
        ST_DIV,
        ST_OUT
    } t_state;

    t_state                      r_state;
    logic [mafe_pkg::ITER_W-1:0] r_iter;
    logic                        r_out_valid;
    logic                        in_accept;
    logic                        out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd = '0;
        case (r_state)
            ST_IDLE:  o_cmd.take      = in_accept;
            ST_UPD:   o_cmd.upd       = 1'b1;
            ST_SQ:    o_cmd.sq        = 1'b1;
            ST_ACC:   o_cmd.acc       = 1'b1;
            ST_RINIT: o_cmd.root_init = 1'b1;
            ST_ROOT:  o_cmd.root_step = 1'b1;
            ST_DINIT: o_cmd.div_init  = 1'b1;
            ST_DIV:   o_cmd.div_step  = 1'b1;
            ST_OUT:   o_cmd.load_out  = out_free;
            default:  o_cmd = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_iter      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // A new result word may replace the one taken in the same cycle.
            if (r_state == ST_OUT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (in_accept) begin
                        r_state <= ST_UPD;
                    end
                end
                ST_UPD: r_state <= ST_SQ;
                ST_SQ:  r_state <= ST_ACC;
                ST_ACC: begin
                    // A bad configuration skips the root and the division.
                    if (!i_stat.last) begin
                        r_state <= ST_IDLE;
                    end else if (i_stat.bad) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_state <= ST_RINIT;
                    end
                end
                ST_RINIT: begin
                    r_iter  <= '0;
                    r_state <= ST_ROOT;
                end
                ST_ROOT: begin
                    if (r_iter == mafe_pkg::ITER_W'(mafe_pkg::ROOT_STEPS - 1)) begin
                        r_state <= ST_DINIT;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                ST_DINIT: begin
                    r_iter  <= '0;
                    r_state <= ST_DIV;
                end
                ST_DIV: begin
                    if (r_iter == mafe_pkg::ITER_W'(mafe_pkg::DIV_STEPS - 1)) begin
                        r_state <= ST_OUT;
                    end else begin
                        r_iter <= r_iter + 1'b1;
                    end
                end
                ST_OUT: begin
                    if (out_free) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    a_load_when_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load_out |-> out_free)
        else $error("result loaded over a word not yet taken");

    a_take_then_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_accept |=> (r_state == ST_UPD))
        else $error("accepted sample not followed by window update");

    a_iter_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROOT || r_state == ST_DIV) |->
            (r_iter < mafe_pkg::ITER_W'(mafe_pkg::ROOT_STEPS)))
        else $error("iteration counter out of range");

endmodule

### hdl/mafe_datapath.sv
// ----------------------------------------------------------------------------
// mafe_datapath
// Configuration registers, sample window, squared-error accumulator and the
// iterative square root and divider.
// ----------------------------------------------------------------------------
module mafe_datapath #(
    parameter int MAX_WINDOW = 256
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [mafe_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [mafe_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    input  logic signed [mafe_pkg::SAMPLE_W-1:0]   i_sample,
    input  mafe_pkg::t_cmd                         i_cmd,
    output mafe_pkg::t_stat                        o_stat,
    output logic [mafe_pkg::RMS_W-1:0]             o_rms,
    output logic                                   o_bad
);

    localparam int AW = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [mafe_pkg::WLEN_W-1:0]          r_wlen;
    logic [mafe_pkg::SLEN_W-1:0]          r_slen;
    logic signed [mafe_pkg::TOTAL_W-1:0]  r_total;
    logic [mafe_pkg::ERR_W-1:0]           r_err;
    logic [mafe_pkg::SLEN_W-1:0]          r_count;
    logic [AW-1:0]                        r_slot;

    logic signed [mafe_pkg::SAMPLE_W-1:0] r_sample;
    logic signed [mafe_pkg::DIFF_W-1:0]   r_diff;
    logic [mafe_pkg::SQ_W-1:0]            r_sq;
    logic [mafe_pkg::ERR_W-1:0]           r_rad;
    logic [mafe_pkg::ROOT_W-1:0]          r_root;
    logic [mafe_pkg::REM_W-1:0]           r_rem;
    logic [mafe_pkg::DEN_W-1:0]           r_den;
    logic [mafe_pkg::ROOT_W-1:0]          r_dq;
    logic [mafe_pkg::DEN_W-1:0]           r_drem;
    logic [mafe_pkg::RMS_W-1:0]           r_rms;
    logic                                 r_bad;

    logic [mafe_pkg::SAMPLE_W-1:0]        ram_rdata;
    logic                                 ram_we;
    logic [mafe_pkg::SLEN_W-1:0]          n_eff;
    logic                                 w_ok;
    logic                                 in_fill;
    logic                                 clear;
    logic signed [mafe_pkg::PROD_W-1:0]   prod;
    logic signed [mafe_pkg::DIFF_W-1:0]   n_diff;
    logic signed [mafe_pkg::TOTAL_W-1:0]  n_total;
    logic [mafe_pkg::ABS_W-1:0]           abs_d;
    logic [mafe_pkg::SQ_W-1:0]            n_sq;
    logic [mafe_pkg::ERR_W:0]             err_sum;
    logic [mafe_pkg::ERR_W-1:0]           n_err;
    logic [AW-1:0]                        n_slot;
    logic [mafe_pkg::REM_W+1:0]           rem_sh;
    logic [mafe_pkg::REM_W+1:0]           trial;
    logic                                 root_ge;
    logic [mafe_pkg::DEN_W:0]             drem_sh;
    logic                                 div_ge;
    logic [mafe_pkg::DEN_W-1:0]           n_den;
    logic [mafe_pkg::RMS_W-1:0]           n_rms;

    assign n_eff   = (r_slen == '0) ? mafe_pkg::SLEN_W'(1) : r_slen;
    assign w_ok    = (r_wlen != '0) && (32'(r_wlen) <= MAX_WINDOW);
    assign in_fill = r_count < mafe_pkg::SLEN_W'(r_wlen);
    assign clear   = i_cfg_we || i_cmd.load_out;

    assign o_stat.last = (mafe_pkg::SLEN_W'(1) + r_count == n_eff) ||
                         ({1'b0, r_count} + 1'b1 > {1'b0, n_eff});
    assign o_stat.bad  = !w_ok || (n_eff <= mafe_pkg::SLEN_W'(r_wlen));

    // Prediction error scaled by the window length, so no division is needed.
    assign prod    = $signed({1'b0, r_wlen}) * r_sample;
    assign n_diff  = mafe_pkg::DIFF_W'(prod) - mafe_pkg::DIFF_W'(r_total);
    assign n_total = in_fill ?
        r_total + mafe_pkg::TOTAL_W'(r_sample) :
        r_total + mafe_pkg::TOTAL_W'(r_sample)
                - mafe_pkg::TOTAL_W'($signed(ram_rdata));

    assign abs_d   = r_diff[mafe_pkg::DIFF_W-1] ? mafe_pkg::ABS_W'(-r_diff)
                                                 : mafe_pkg::ABS_W'(r_diff);
    assign n_sq    = mafe_pkg::SQ_W'(abs_d) * mafe_pkg::SQ_W'(abs_d);
    assign err_sum = {1'b0, r_err} + (mafe_pkg::ERR_W + 1)'(r_sq);
    assign n_err   = err_sum[mafe_pkg::ERR_W] ? '1 : err_sum[mafe_pkg::ERR_W-1:0];

    assign n_slot  = (32'(r_slot) == 32'(r_wlen) - 32'd1) ? '0 : r_slot + 1'b1;

    // One digit pair of the root of error_total * 2^32 per step; the radicand
    // shifts in zeros once the accumulator bits are used up.
    assign rem_sh  = {r_rem, r_rad[mafe_pkg::ERR_W-1 -: 2]};
    assign trial   = {1'b0, r_root, 2'b01};
    assign root_ge = rem_sh >= trial;

    assign drem_sh = {r_drem, r_dq[mafe_pkg::ROOT_W-1]};
    assign div_ge  = drem_sh >= {1'b0, r_den};

    assign n_den   = mafe_pkg::DEN_W'(r_wlen) *
                     mafe_pkg::DEN_W'(n_eff - mafe_pkg::SLEN_W'(r_wlen));
    assign n_rms   = (r_dq[mafe_pkg::ROOT_W-1:mafe_pkg::RMS_W] != '0) ? '1
                                                   : r_dq[mafe_pkg::RMS_W-1:0];

    assign ram_we  = i_cmd.upd && w_ok;

    mafe_ram #(
        .WIDTH (mafe_pkg::SAMPLE_W),
        .DEPTH (MAX_WINDOW)
    ) u_window (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (r_slot),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlen  <= mafe_pkg::WLEN_RESET;
            r_slen  <= mafe_pkg::SLEN_RESET;
            r_total <= '0;
            r_err   <= '0;
            r_count <= '0;
            r_slot  <= '0;
        end else if (clear) begin
            r_total <= '0;
            r_err   <= '0;
            r_count <= '0;
            r_slot  <= '0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    mafe_pkg::CFG_WINDOW_LEN: r_wlen <= i_cfg_data[mafe_pkg::WLEN_W-1:0];
                    mafe_pkg::CFG_SERIES_LEN: r_slen <= i_cfg_data;
                    default: ;
                endcase
            end
        end else begin
            if (i_cmd.upd && w_ok) begin
                r_total <= n_total;
            end
            if (i_cmd.acc) begin
                r_count <= r_count + 1'b1;
                if (w_ok) begin
                    r_slot <= n_slot;
                    if (!in_fill) begin
                        r_err <= n_err;
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sample <= i_sample;
        end
        if (i_cmd.upd) begin
            r_diff <= n_diff;
        end
        if (i_cmd.sq) begin
            r_sq <= n_sq;
        end
        if (i_cmd.root_init) begin
            r_rad  <= r_err;
            r_root <= '0;
            r_rem  <= '0;
        end
        if (i_cmd.root_step) begin
            r_rad <= {r_rad[mafe_pkg::ERR_W-3:0], 2'b00};
            if (root_ge) begin
                r_rem  <= mafe_pkg::REM_W'(rem_sh - trial);
                r_root <= {r_root[mafe_pkg::ROOT_W-2:0], 1'b1};
            end else begin
                r_rem  <= rem_sh[mafe_pkg::REM_W-1:0];
                r_root <= {r_root[mafe_pkg::ROOT_W-2:0], 1'b0};
            end
        end
        if (i_cmd.div_init) begin
            r_den  <= n_den;
            r_dq   <= r_root;
            r_drem <= '0;
        end
        if (i_cmd.div_step) begin
            r_dq <= {r_dq[mafe_pkg::ROOT_W-2:0], div_ge};
            if (div_ge) begin
                r_drem <= mafe_pkg::DEN_W'(drem_sh - {1'b0, r_den});
            end else begin
                r_drem <= drem_sh[mafe_pkg::DEN_W-1:0];
            end
        end
        if (i_cmd.load_out) begin
            r_rms <= o_stat.bad ? '0 : n_rms;
            r_bad <= o_stat.bad;
        end
    end

    assign o_rms = r_rms;
    assign o_bad = r_bad;

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ok |-> (32'(r_slot) < 32'(r_wlen)))
        else $error("window slot beyond window length");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= n_eff)
        else $error("sample count ran past the series length");

    a_bad_gives_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load_out && o_stat.bad) |=> (r_rms == '0 && r_bad))
        else $error("bad configuration result is not zero");

endmodule

### hdl/moving_average_forecast_error.sv
// ----------------------------------------------------------------------------
// moving_average_forecast_error
// Moving-average forecast RMS error over one series of samples at a time.
// ----------------------------------------------------------------------------
// Each accepted sample passes through take and window read, window update,
// square and accumulate, and the input takes no new sample until all of these
// are done. The last sample of a well-configured series adds a 45-step square
// root, a 45-step division and a setup step ahead of each, before the result
// word is loaded; the window memory's single read port and the
// one-bit-per-cycle root and divider shape these steps. The result word sits
// in an output register, so the next series starts while it waits to be
// taken. The result is sqrt(sum of squared errors)/(series_len - window_len)
// in unsigned Q16.16; a series not longer than the window, or a window of
// zero or above MAX_WINDOW, gives zero with bad_config set. Any configuration
// write starts a fresh series; write only while the block is idle.
// ----------------------------------------------------------------------------
module moving_average_forecast_error #(
    parameter int MAX_WINDOW = 256
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mafe_sample_if.sink   i_sample_if,
    mafe_result_if.source o_result_if,
    mafe_cfg_if.sink      i_cfg_if
);

    mafe_pkg::t_cmd  cmd;
    mafe_pkg::t_stat stat;
    logic            cfg_we;

    assign i_cfg_if.ready = 1'b1;
    assign cfg_we         = i_cfg_if.valid && i_cfg_if.ready;

    mafe_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_sample_if.valid),
        .o_in_ready  (i_sample_if.ready),
        .o_out_valid (o_result_if.valid),
        .i_out_ready (o_result_if.ready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    mafe_datapath #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (i_cfg_if.index),
        .i_cfg_data  (i_cfg_if.data),
        .i_sample    (i_sample_if.sample),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .o_rms       (o_result_if.rms_result),
        .o_bad       (o_result_if.bad_config)
    );

endmodule
